@@ rtl/core/whp_pkg.sv @@
// Shared types and constants for the WAV header parser.
// No dependencies.
`default_nettype none
package whp_pkg;

  localparam logic [31:0] MagicRiff = 32'h52494646;
  localparam logic [31:0] MagicWave = 32'h57415645;
  localparam logic [31:0] MagicFmt  = 32'h666d7420;
  localparam logic [31:0] MagicData = 32'h64617461;
  localparam logic [31:0] RateMax   = 32'd96000;
  localparam logic [31:0] RateMin   = 32'd100;
  localparam logic [31:0] FmtBase   = 32'd16;

  localparam logic [1:0] ActByte    = 2'd0;
  localparam logic [1:0] ActEnd     = 2'd1;
  localparam logic [1:0] ActRestart = 2'd2;

  localparam logic [1:0] StParsing = 2'd0;
  localparam logic [1:0] StDone    = 2'd1;
  localparam logic [1:0] StError   = 2'd2;

  localparam logic [3:0] ErrNone      = 4'd0;
  localparam logic [3:0] ErrNotRiff   = 4'd1;
  localparam logic [3:0] ErrNotWave   = 4'd2;
  localparam logic [3:0] ErrNoFmt     = 4'd3;
  localparam logic [3:0] ErrNotPcm    = 4'd4;
  localparam logic [3:0] ErrBadExt    = 4'd5;
  localparam logic [3:0] ErrBadMeta   = 4'd6;
  localparam logic [3:0] ErrFmtPlace  = 4'd7;
  localparam logic [3:0] ErrTruncated = 4'd8;
  localparam logic [3:0] ErrOverflow  = 4'd9;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_END,
    CMD_RESTART,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_FMT,
    PH_EXTLEN,
    PH_EXTSKIP,
    PH_CHUNK,
    PH_DATALEN,
    PH_SKIPLEN,
    PH_SKIP,
    PH_PAD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  error_kind;
    logic [1:0]  channels;
    logic [16:0] sample_rate;
    logic [2:0]  bytes_per_frame;
    logic        eight_bit_format;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/whp_fifo.sv @@
// Two-entry queue with registered storage.
// No package dependency.
`default_nettype none
module whp_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= ~wptr_r;
      if (do_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end
endmodule
`default_nettype wire

@@ rtl/core/whp_front.sv @@
// Front end: decodes the input action into a command and queues it.
// Depends on whp_pkg and whp_fifo.
`default_nettype none
module whp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [1:0]    action,
  input  wire logic [7:0]    data_byte,
  output logic               full,
  input  wire logic          cmd_pop,
  output whp_pkg::cmd_t      cmd,
  output logic               cmd_empty
);
  import whp_pkg::*;

  cmd_t       cmd_in;
  logic [$bits(cmd_t)-1:0] rd_bits;

  always_comb begin
    cmd_in.data = data_byte;
    unique case (action)
      ActByte:    cmd_in.kind = CMD_BYTE;
      ActEnd:     cmd_in.kind = CMD_END;
      ActRestart: cmd_in.kind = CMD_RESTART;
      default:    cmd_in.kind = CMD_NOP;
    endcase
  end

  whp_fifo #(.WIDTH($bits(cmd_t))) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (rd_bits),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(rd_bits);
endmodule
`default_nettype wire

@@ rtl/core/whp_back.sv @@
// Back end: RIFF/WAVE parse state machine, one command per cycle while fire is high.
// Depends on whp_pkg.
`default_nettype none
module whp_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  whp_pkg::cmd_t    cmd,
  output whp_pkg::result_t res
);
  import whp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [31:0] fsize_r, fsize_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] frame_r, frame_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [32:0] pos_r, pos_nxt;
  logic [31:0] plen_r, plen_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic [3:0]  err_r, err_nxt;

  logic [31:0] le32v;
  logic [15:0] le16v;
  logic        meta_ok_cur, meta_ok_fmt;
  logic        ok;

  function automatic logic meta_ok(input logic [31:0] rate, input logic [15:0] ch,
                                   input logic [15:0] fb, input logic [15:0] bps);
    meta_ok = (rate >= RateMin) && (rate <= RateMax) && (ch >= 16'd1) && (ch <= 16'd2)
           && (fb == 16'd1 || fb == 16'd2 || fb == 16'd4)
           && (bps == 16'd8 || bps == 16'd16);
  endfunction

  assign asm_nxt     = {asm_r[23:0], cmd.data};
  assign le32v       = {asm_nxt[7:0], asm_nxt[15:8], asm_nxt[23:16], asm_nxt[31:24]};
  assign le16v       = {asm_nxt[7:0], asm_nxt[15:8]};
  assign meta_ok_cur = meta_ok(rate_r, chan_r, frame_r, bits_r);
  assign meta_ok_fmt = meta_ok(rate_r, chan_r, frame_r, le16v);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    fsize_nxt = fsize_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    frame_nxt = frame_r;
    bits_nxt  = bits_r;
    skip_nxt  = skip_r;
    pos_nxt   = pos_r;
    plen_nxt  = plen_r;
    stat_nxt  = stat_r;
    err_nxt   = err_r;
    if (fire) begin
      if (cmd.kind == CMD_RESTART) begin
        phase_nxt = PH_RIFF;
        idx_nxt   = '0;
        fsize_nxt = '0;
        chan_nxt  = '0;
        rate_nxt  = '0;
        frame_nxt = '0;
        bits_nxt  = '0;
        skip_nxt  = '0;
        pos_nxt   = '0;
        plen_nxt  = '0;
        stat_nxt  = StParsing;
        err_nxt   = ErrNone;
      end else if (cmd.kind == CMD_END && stat_r == StParsing) begin
        phase_nxt = PH_ERROR;
        stat_nxt  = StError;
        err_nxt   = ErrTruncated;
      end else if (cmd.kind == CMD_BYTE && stat_r == StParsing) begin
        if (pos_r != {33{1'b1}}) pos_nxt = pos_r + 33'd1;
        idx_nxt = idx_r + 5'd1;
        unique case (phase_r)
          PH_RIFF: begin
            if (idx_r == 5'd3 && asm_nxt != MagicRiff) begin
              phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrNotRiff;
            end else if (idx_r == 5'd11) begin
              if (asm_nxt != MagicWave) begin
                phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrNotWave;
              end else begin
                phase_nxt = PH_FMT; idx_nxt = '0;
              end
            end
          end
          PH_FMT: begin
            case (idx_r)
              5'd3: if (asm_nxt != MagicFmt) begin
                phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrNoFmt;
              end
              5'd7: fsize_nxt = le32v;
              5'd9: if (le16v != 16'd1) begin
                phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrNotPcm;
              end
              5'd11: chan_nxt = le16v;
              5'd15: rate_nxt = le32v;
              5'd21: frame_nxt = le16v;
              5'd23: begin
                bits_nxt = le16v;
                if (fsize_r > FmtBase) begin
                  phase_nxt = PH_EXTLEN; idx_nxt = '0;
                end else if (!meta_ok_fmt) begin
                  phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrBadMeta;
                end else begin
                  phase_nxt = PH_CHUNK; idx_nxt = '0;
                end
              end
              default: ;
            endcase
          end
          PH_EXTLEN: begin
            if (idx_r == 5'd1) begin
              if (fsize_r - (FmtBase + 32'd2) != {16'd0, le16v}) begin
                phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrBadExt;
              end else begin
                skip_nxt = 32'({1'b0, le16v} + {16'd0, le16v[0]});
                if (le16v == 16'd0) begin
                  if (!meta_ok_cur) begin
                    phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrBadMeta;
                  end else begin
                    phase_nxt = PH_CHUNK; idx_nxt = '0;
                  end
                end else begin
                  phase_nxt = PH_EXTSKIP; idx_nxt = '0;
                end
              end
            end
          end
          PH_EXTSKIP: begin
            skip_nxt = skip_r - 32'd1;
            if (skip_r == 32'd1) begin
              if (!meta_ok_cur) begin
                phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrBadMeta;
              end else begin
                phase_nxt = PH_CHUNK; idx_nxt = '0;
              end
            end
          end
          PH_CHUNK: begin
            if (idx_r == 5'd3) begin
              idx_nxt = '0;
              if (asm_nxt == MagicData) phase_nxt = PH_DATALEN;
              else if (asm_nxt == MagicFmt) begin
                phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrFmtPlace;
                idx_nxt = idx_r + 5'd1;
              end else phase_nxt = PH_SKIPLEN;
            end
          end
          PH_DATALEN: begin
            if (idx_r == 5'd3) begin
              plen_nxt = le32v;
              if (pos_nxt[32]) begin
                phase_nxt = PH_ERROR; stat_nxt = StError; err_nxt = ErrOverflow;
              end else begin
                phase_nxt = PH_DONE; idx_nxt = '0; stat_nxt = StDone;
              end
            end
          end
          PH_SKIPLEN: begin
            if (idx_r == 5'd3) begin
              skip_nxt = le32v;
              if (le32v == 32'd0) begin
                phase_nxt = PH_CHUNK; idx_nxt = '0;
              end else begin
                // idx holds the pad flag during the skip
                phase_nxt = PH_SKIP; idx_nxt = {4'd0, le32v[0]};
              end
            end
          end
          PH_SKIP: begin
            idx_nxt  = idx_r;
            skip_nxt = skip_r - 32'd1;
            if (skip_r == 32'd1) begin
              phase_nxt = (idx_r != 5'd0) ? PH_PAD : PH_CHUNK;
              idx_nxt   = '0;
            end
          end
          PH_PAD: begin
            phase_nxt = PH_CHUNK; idx_nxt = '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      idx_r   <= '0;
      asm_r   <= '0;
      fsize_r <= '0;
      chan_r  <= '0;
      rate_r  <= '0;
      frame_r <= '0;
      bits_r  <= '0;
      skip_r  <= '0;
      pos_r   <= '0;
      plen_r  <= '0;
      stat_r  <= StParsing;
      err_r   <= ErrNone;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      if (fire) begin
        if (cmd.kind == CMD_RESTART) asm_r <= '0;
        else if (cmd.kind == CMD_BYTE && stat_r == StParsing) asm_r <= asm_nxt;
      end
      fsize_r <= fsize_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      frame_r <= frame_nxt;
      bits_r  <= bits_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
      plen_r  <= plen_nxt;
      stat_r  <= stat_nxt;
      err_r   <= err_nxt;
    end
  end

  // result reflects state after this beat
  assign ok = (stat_nxt == StDone);
  always_comb begin
    res.status           = stat_nxt;
    res.error_kind       = err_nxt;
    res.channels         = ok ? chan_nxt[1:0] : 2'd0;
    res.sample_rate      = ok ? rate_nxt[16:0] : 17'd0;
    res.bytes_per_frame  = ok ? frame_nxt[2:0] : 3'd0;
    res.eight_bit_format = ok && (bits_nxt == 16'd8);
    res.data_offset      = ok ? pos_nxt[31:0] : 32'd0;
    res.data_length      = ok ? plen_nxt : 32'd0;
  end
endmodule
`default_nettype wire

@@ rtl/core/wav_header_parser.sv @@
// Path: an accepted input beat is registered in the command queue, then its result is registered
// in the result queue, whose head drives the outputs; a full result queue stalls the parser.
// Throughput: one byte per cycle while the result queue has room; the parse state machine takes one command per cycle.
// Both sides are two-entry queues, so a held result does not stop input until both fill.
// Reset (rst_n low, synchronous) empties the queues and returns the parser to
// expecting the RIFF header.
`default_nettype none
module wav_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_status,
  output logic [3:0]       out_error_kind,
  output logic [1:0]       out_channels,
  output logic [16:0]      out_sample_rate,
  output logic [2:0]       out_bytes_per_frame,
  output logic             out_eight_bit_format,
  output logic [31:0]      out_data_offset,
  output logic [31:0]      out_data_length
);
  import whp_pkg::*;

  cmd_t    cmd;
  logic    cmd_empty, fire, res_full;
  result_t res, head;
  logic [$bits(result_t)-1:0] head_bits;

  assign fire = !cmd_empty && !res_full;

  whp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .action    (in_action),
    .data_byte (in_data_byte),
    .full      (full),
    .cmd_pop   (fire),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  whp_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cmd   (cmd),
    .res   (res)
  );

  whp_fifo #(.WIDTH($bits(result_t))) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (head_bits),
    .empty (empty)
  );

  assign head                 = result_t'(head_bits);
  assign out_status           = head.status;
  assign out_error_kind       = head.error_kind;
  assign out_channels         = head.channels;
  assign out_sample_rate      = head.sample_rate;
  assign out_bytes_per_frame  = head.bytes_per_frame;
  assign out_eight_bit_format = head.eight_bit_format;
  assign out_data_offset      = head.data_offset;
  assign out_data_length      = head.data_length;
endmodule
`default_nettype wire
